@@ rtl/lsgs_pkg.sv @@
// ----------------------------------------------------------------------------
// lsgs_pkg
// Shared types and constants for the greedy load stage selector.
// ----------------------------------------------------------------------------
package lsgs_pkg;

  localparam int STAGE_COUNT = 16;
  localparam int STAGE_W     = $clog2(STAGE_COUNT);
  localparam int DIV_W       = 40;   // dividend and quotient width
  localparam int DVS_W       = 20;   // divisor width
  localparam int CNT_W       = $clog2(DIV_W + 1);

  localparam logic [17:0] MIN_VOLTAGE_RST = 18'd2000;
  localparam logic [9:0]  THRESHOLD_RST   = 10'd5;
  localparam logic [30:0] HELD_ERROR_RST  = 31'h7FFF_FFFF;
  localparam logic [9:0]  MILLI           = 10'd1000;
  localparam logic [29:0] GIGA            = 30'd1_000_000_000;
  localparam logic [19:0] RESID_MAX       = 20'hF_FFFF;
  // ceil(2^48 / 1000), exact floor of x / 1000 for any x below 2^38
  localparam logic [38:0] RECIP_MILLI     = 39'd281474976711;

  typedef enum logic [1:0] {
    REG_MIN_VOLTAGE = 2'd0,
    REG_THRESHOLD   = 2'd1,
    REG_CONST_MODE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [0:0] {
    MODE_WRITE  = 1'b0,
    MODE_SELECT = 1'b1
  } item_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TGT,
    ST_SCAN,
    ST_PREC,
    ST_PSQR,
    ST_PMUL,
    ST_PCMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                    start;
    logic [DIV_W-1:0]        dividend;
    logic [DVS_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [DIV_W-1:0]        quotient;
  } div_rsp_t;

endpackage

@@ rtl/lsgs_div.sv @@
// ----------------------------------------------------------------------------
// lsgs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsgs_div (
  input  logic              clk,
  input  logic              rst,
  input  lsgs_pkg::div_req_t req,
  output lsgs_pkg::div_rsp_t rsp
);
  import lsgs_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DIV_W-1:0] quo;
  logic             done;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;

  assign rem_sh = {rem, quo[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= req.divisor;
      quo <= req.dividend;
    end else if (busy) begin
      // no borrow when the shifted remainder covers the divisor
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= diff[DVS_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DVS_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ rtl/load_stage_greedy_select.sv @@
// A write is stored in the stage table when accepted; an undervoltage select skips to the emit state.
// A select runs the target divide, then ordering passes (one table entry per cycle, up to 17
// passes), and for each stage that gets the power check a reciprocal multiply for the divide
// by 1000, a square, a scale and a compare.
// One item at a time: not ready until the result is handed to the output register.
// Synchronous reset empties the stage table (valid bits) and resets held state, control and config.
// ----------------------------------------------------------------------------
// load_stage_greedy_select
// Greedy stage selection for a stepped electronic load, with hysteresis.
// ----------------------------------------------------------------------------
module load_stage_greedy_select (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [3:0]  stage_index,
  input  logic [19:0] nominal_g,
  input  logic [19:0] calibrated_conductance,
  input  logic [15:0] rated_watts,
  input  logic [15:0] load_milliohm,
  input  logic [19:0] set_point_ma,
  input  logic [17:0] sense_mv,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] stage_mask,
  output logic        undervoltage,
  output logic        new_solution,
  output logic [19:0] residual_conductance
);
  import lsgs_pkg::*;

  localparam logic [STAGE_W-1:0] LAST = STAGE_W'(STAGE_COUNT - 1);

  state_t state, state_next;

  logic [17:0] min_voltage;
  logic [9:0]  threshold;
  logic        const_mode;

  logic [19:0] tab_nom [STAGE_COUNT];
  logic [19:0] tab_cal [STAGE_COUNT];
  logic [15:0] tab_rat [STAGE_COUNT];
  logic [15:0] tab_res [STAGE_COUNT];
  logic [STAGE_COUNT-1:0] tab_vld;

  logic [30:0] held_error;
  logic [15:0] held_mask;
  logic [19:0] held_sp;

  logic [19:0] sel_sp;
  logic [17:0] sel_vmv;
  logic        sel_uv;
  logic [29:0] remaining;
  logic [STAGE_COUNT-1:0] mask;
  logic [STAGE_COUNT-1:0] done_set;
  logic [STAGE_W-1:0] scan_idx;
  logic        best_found;
  logic [19:0] best_g;
  logic [STAGE_W-1:0] best_idx;
  logic [19:0] pick_g;
  logic [STAGE_W-1:0] pick_idx;
  logic [37:0] prod;
  logic [1:0]  rstep;
  logic [76:0] racc;
  logic [57:0] cur2;
  logic [46:0] limit;
  logic [44:0] p_hi;
  logic [44:0] p_lo;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_fire, out_load, uv_now;
  logic [19:0] cur_eff;
  logic take_cur, cand_found;
  logic [19:0] cand_g;
  logic [STAGE_W-1:0] cand_idx;
  logic [18:0] pp_a;
  logic [19:0] pp_b;
  logic [38:0] pp;
  logic [76:0] pp_sh;
  logic [73:0] pwr;
  logic [32:0] err_drop;
  logic take_new;

  function automatic logic [19:0] eff_of(input logic vld, input logic [19:0] cal,
                                         input logic [19:0] nom);
    logic [19:0] g;
    g = (cal != '0) ? cal : nom;
    return vld ? g : '0;
  endfunction

  assign div_req = '{start: div_start, dividend: div_dividend, divisor: div_divisor};

  lsgs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign uv_now    = (sense_mv == '0) || (sense_mv < min_voltage);
  assign out_load  = (state == ST_EMIT) && (!out_valid || out_ready);

  // scan: running maximum over entries not yet picked, lower index wins ties
  assign cur_eff    = eff_of(tab_vld[scan_idx], tab_cal[scan_idx], tab_nom[scan_idx]);
  assign take_cur   = !done_set[scan_idx] && (!best_found || cur_eff > best_g);
  assign cand_found = best_found || take_cur;
  assign cand_g     = take_cur ? cur_eff : best_g;
  assign cand_idx   = take_cur ? scan_idx : best_idx;

  // partial products of prod * RECIP_MILLI, one per cycle; bits 76:48 give prod / 1000
  assign pp_a = rstep[1] ? prod[37:19] : prod[18:0];
  assign pp_b = rstep[0] ? {1'b0, RECIP_MILLI[38:20]} : RECIP_MILLI[19:0];
  assign pp   = 39'(pp_a) * 39'(pp_b);

  always_comb begin
    case (rstep)
      2'd0:    pp_sh = {38'b0, pp};
      2'd1:    pp_sh = {18'b0, pp, 20'b0};
      2'd2:    pp_sh = {19'b0, pp, 19'b0};
      default: pp_sh = {pp[37:0], 39'b0};
    endcase
  end

  assign pwr      = {p_hi, 29'b0} + {29'b0, p_lo};
  assign err_drop = {2'b0, held_error} - {3'b0, remaining};
  assign take_new = ($signed(err_drop) > $signed({23'b0, threshold})) || (held_sp != sel_sp);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && item_mode_t'(mode) == MODE_SELECT) begin
          state_next = uv_now ? ST_EMIT : ST_TGT;
        end
      end
      ST_TGT: begin
        if (div_rsp.done) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_idx == LAST) begin
          if (!cand_found || cand_g == '0) begin
            state_next = ST_EMIT;
          end else if ({10'b0, cand_g} <= remaining && const_mode
                       && tab_res[cand_idx] != '0) begin
            state_next = ST_PREC;
          end
        end
      end
      ST_PREC: begin
        if (rstep == 2'd3) state_next = ST_PSQR;
      end
      ST_PSQR: state_next = ST_PMUL;
      ST_PMUL: state_next = ST_PCMP;
      ST_PCMP: state_next = ST_SCAN;
      ST_EMIT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_voltage <= MIN_VOLTAGE_RST;
      threshold   <= THRESHOLD_RST;
      const_mode  <= 1'b1;
      tab_vld     <= '0;
      held_error  <= HELD_ERROR_RST;
      held_mask   <= '0;
      held_sp     <= '0;
      out_valid   <= 1'b0;
      div_start   <= 1'b0;
    end else begin
      div_start <= in_fire && item_mode_t'(mode) == MODE_SELECT && !uv_now;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MIN_VOLTAGE: min_voltage <= cfg_data;
          REG_THRESHOLD:   threshold   <= cfg_data[9:0];
          REG_CONST_MODE:  const_mode  <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_fire && item_mode_t'(mode) == MODE_WRITE
          && {1'b0, stage_index} < 5'(STAGE_COUNT)) begin
        tab_vld[stage_index[STAGE_W-1:0]] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (out_load && !sel_uv && take_new) begin
        held_error <= {1'b0, remaining};
        held_mask  <= mask[15:0];
        held_sp    <= sel_sp;
      end
    end
  end

  // payload: table entries, datapath and output registers
  always_ff @(posedge clk) begin
    if (in_fire && item_mode_t'(mode) == MODE_WRITE) begin
      tab_nom[stage_index[STAGE_W-1:0]] <= nominal_g;
      tab_cal[stage_index[STAGE_W-1:0]] <= calibrated_conductance;
      tab_rat[stage_index[STAGE_W-1:0]] <= rated_watts;
      tab_res[stage_index[STAGE_W-1:0]] <= load_milliohm;
    end
    if (in_fire) begin
      sel_sp  <= set_point_ma;
      sel_vmv <= sense_mv;
      sel_uv  <= uv_now;
      div_dividend <= DIV_W'(30'(set_point_ma) * 30'(MILLI));
      div_divisor  <= DVS_W'(sense_mv);
    end
    case (state)
      ST_TGT: begin
        remaining  <= div_rsp.quotient[29:0];
        mask       <= '0;
        done_set   <= '0;
        scan_idx   <= '0;
        best_found <= 1'b0;
      end
      ST_SCAN: begin
        if (scan_idx == LAST) begin
          scan_idx   <= '0;
          best_found <= 1'b0;
          pick_g     <= cand_g;
          pick_idx   <= cand_idx;
          if (cand_found) done_set[cand_idx] <= 1'b1;
          prod  <= 38'(sel_vmv) * 38'(cand_g);
          racc  <= '0;
          rstep <= '0;
          // stages without a power check are taken right away
          if (cand_found && cand_g != '0 && {10'b0, cand_g} <= remaining
              && !(const_mode && tab_res[cand_idx] != '0)) begin
            mask[cand_idx] <= 1'b1;
            remaining      <= remaining - {10'b0, cand_g};
          end
        end else begin
          scan_idx   <= scan_idx + 1'b1;
          best_found <= cand_found;
          best_g     <= cand_g;
          best_idx   <= cand_idx;
        end
      end
      ST_PREC: begin
        racc  <= racc + pp_sh;
        rstep <= rstep + 1'b1;
      end
      ST_PSQR: begin
        cur2  <= 58'(racc[76:48]) * 58'(racc[76:48]);
        limit <= 47'({1'b0, tab_rat[pick_idx]} + 17'd1) * 47'(GIGA);
      end
      ST_PMUL: begin
        p_hi <= 45'(cur2[57:29]) * 45'(tab_res[pick_idx]);
        p_lo <= 45'(cur2[28:0]) * 45'(tab_res[pick_idx]);
      end
      ST_PCMP: begin
        if (pwr < {27'b0, limit}) begin
          mask[pick_idx] <= 1'b1;
          remaining      <= remaining - {10'b0, pick_g};
        end
      end
      default: ;
    endcase
    if (out_load) begin
      if (sel_uv) begin
        stage_mask           <= '0;
        undervoltage         <= 1'b1;
        new_solution         <= 1'b0;
        residual_conductance <= '0;
      end else begin
        stage_mask           <= take_new ? mask[15:0] : held_mask;
        undervoltage         <= 1'b0;
        new_solution         <= take_new;
        residual_conductance <= (remaining > {10'b0, RESID_MAX}) ? RESID_MAX
                                                                 : remaining[19:0];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_uv_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && undervoltage |-> stage_mask == '0 && !new_solution)
    else $error("undervoltage result carries a mask");

  a_mask_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_solution |-> (stage_mask & ~tab_vld[15:0]) == '0)
    else $error("fresh mask selects an empty stage");

  a_remaining_down: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && $past(state == ST_SCAN) |-> remaining <= $past(remaining))
    else $error("remaining conductance grew during selection");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_TGT)
    else $error("divider finished outside a divide step");
`endif

endmodule
